// ===== design/rfpd_pkg.sv =====
package rfpd_pkg;

  localparam int AccelW = 16;
  localparam int AltW   = 24;
  localparam int RunW   = 8;
  localparam int PhaseW = 3;

  // flight phase codes
  localparam logic [PhaseW-1:0] PH_IDLE    = 3'd0;
  localparam logic [PhaseW-1:0] PH_BOOST   = 3'd1;
  localparam logic [PhaseW-1:0] PH_BURNOUT = 3'd2;
  localparam logic [PhaseW-1:0] PH_COAST   = 3'd3;
  localparam logic [PhaseW-1:0] PH_APOGEE  = 3'd4;
  localparam logic [PhaseW-1:0] PH_DROGUE  = 3'd5;
  localparam logic [PhaseW-1:0] PH_MAIN    = 3'd6;
  localparam logic [PhaseW-1:0] PH_LANDED  = 3'd7;

  // register indexes (byte address = 4 * index)
  localparam logic [2:0] REG_ACCEL_THR  = 3'd0;
  localparam logic [2:0] REG_LAUNCH_ALT = 3'd1;
  localparam logic [2:0] REG_MAIN_ALT   = 3'd2;
  localparam logic [2:0] REG_COAST_N    = 3'd3;
  localparam logic [2:0] REG_APOGEE_N   = 3'd4;

  localparam logic [14:0] ACCEL_THR_RST  = 15'd2942;
  localparam logic [22:0] LAUNCH_ALT_RST = 23'd800;
  localparam logic [22:0] MAIN_ALT_RST   = 23'd16000;
  localparam logic [7:0]  COAST_N_RST    = 8'd100;
  localparam logic [7:0]  APOGEE_N_RST   = 8'd10;

  typedef struct packed {
    logic [14:0] accel_threshold;
    logic [22:0] launch_altitude_threshold;
    logic [22:0] main_chute_altitude;
    logic [7:0]  coast_samples_needed;
    logic [7:0]  apogee_samples_needed;
  } cfg_t;

  typedef struct packed {
    logic [PhaseW-1:0]      phase;
    logic signed [AltW-1:0] last_altitude;
    logic [RunW-1:0]        coast_run;
    logic [RunW-1:0]        apogee_run;
  } trk_state_t;

endpackage

// ===== design/rfpd_phase_logic.sv =====
module rfpd_phase_logic (
  input  rfpd_pkg::cfg_t                        cfg_i,
  input  rfpd_pkg::trk_state_t                  state_i,
  input  logic signed [rfpd_pkg::AccelW-1:0]    accel_z_i,
  input  logic signed [rfpd_pkg::AltW-1:0]      altitude_i,
  output rfpd_pkg::trk_state_t                  state_o
);
  import rfpd_pkg::*;

  logic signed [AccelW-1:0] athr;
  logic signed [AltW-1:0]   lthr;
  logic signed [AltW-1:0]   mthr;
  logic                     acc_hi, acc_lo;
  logic                     alt_up, alt_down;
  logic [RunW-1:0]          coast_bump, apogee_bump;

  // thresholds are unsigned and zero-extend into the signed compare range
  assign athr = $signed({1'b0, cfg_i.accel_threshold});
  assign lthr = $signed({1'b0, cfg_i.launch_altitude_threshold});
  assign mthr = $signed({1'b0, cfg_i.main_chute_altitude});

  assign acc_hi   = accel_z_i > athr;
  assign acc_lo   = accel_z_i < athr;
  assign alt_up   = altitude_i > state_i.last_altitude;
  assign alt_down = altitude_i < state_i.last_altitude;

  // saturating run counters
  assign coast_bump  = (state_i.coast_run == '1) ? state_i.coast_run
                                                 : state_i.coast_run + 1'b1;
  assign apogee_bump = (state_i.apogee_run == '1) ? state_i.apogee_run
                                                  : state_i.apogee_run + 1'b1;

  always_comb begin
    state_o               = state_i;
    state_o.last_altitude = altitude_i;
    case (state_i.phase)
      PH_IDLE: begin
        if (acc_hi || altitude_i > lthr) state_o.phase = PH_BOOST;
      end
      PH_BOOST: begin
        if (acc_lo || alt_up) state_o.phase = PH_BURNOUT;
      end
      PH_BURNOUT: begin
        if (acc_lo) begin
          // a run length of zero fires on the first sample, as bump >= 1
          if (coast_bump >= cfg_i.coast_samples_needed) begin
            state_o.phase     = PH_COAST;
            state_o.coast_run = '0;
          end else begin
            state_o.coast_run = coast_bump;
          end
        end else begin
          state_o.coast_run = '0;
        end
      end
      PH_COAST: begin
        if (alt_down) begin
          if (apogee_bump >= cfg_i.apogee_samples_needed) begin
            state_o.phase      = PH_APOGEE;
            state_o.apogee_run = '0;
          end else begin
            state_o.apogee_run = apogee_bump;
          end
        end else begin
          state_o.apogee_run = '0;
        end
      end
      PH_APOGEE: begin
        state_o.phase = PH_DROGUE;
      end
      PH_DROGUE: begin
        if (altitude_i < mthr) state_o.phase = PH_MAIN;
      end
      PH_MAIN: begin
        if (acc_lo || altitude_i < lthr) state_o.phase = PH_LANDED;
      end
      default: begin
        state_o.phase = state_i.phase;
      end
    endcase
  end

endmodule

// ===== design/rocket_flight_phase_detector.sv =====
// Rocket flight phase detector.
//
// Sensor samples arrive on the s_axis stream, one per transaction:
// tdata[15:0] accel_z (signed, 0.01 m/s^2), tdata[39:16] altitude (signed,
// 1/16 ft). Every sample yields one result on m_axis: tdata[2:0] flight
// phase (idle, boost, burnout, coast, apogee, drogue, main, landed),
// tdata[3] set when this sample changed the phase.
// Thresholds and run lengths sit behind the APB port at byte addresses
// 0x00..0x10; write them only while no sample is in flight.
//
// A result passes through the input register, then the phase decision, which
// is registered into the result register together with the tracker state.
// One sample per cycle is sustained while the receiver takes results; the
// input register drains whenever the result register is empty or being
// taken, so a stalled receiver holds the result and, one sample later,
// backs up s_axis_tready.
// Reset clears the phase to idle, the previous altitude and both run
// counters to zero, and loads the default thresholds and run lengths.
module rocket_flight_phase_detector (
  input  logic        clk_i,
  input  logic        rst_ni,
  // sample stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // [15:0] accel_z, [39:16] altitude
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [2:0] flight_phase, [3] phase_changed, [7:4] zero
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import rfpd_pkg::*;

  cfg_t       cfg_q;
  trk_state_t state_q, state_d;

  logic                     in_valid_q;
  logic signed [AccelW-1:0] accel_q;
  logic signed [AltW-1:0]   alt_q;

  logic              out_valid_q;
  logic [PhaseW-1:0] phase_out_q;
  logic              changed_q;

  logic       advance;
  logic       cfg_wr;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.accel_threshold           <= ACCEL_THR_RST;
      cfg_q.launch_altitude_threshold <= LAUNCH_ALT_RST;
      cfg_q.main_chute_altitude       <= MAIN_ALT_RST;
      cfg_q.coast_samples_needed      <= COAST_N_RST;
      cfg_q.apogee_samples_needed     <= APOGEE_N_RST;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_ACCEL_THR:  cfg_q.accel_threshold           <= pwdata[14:0];
        REG_LAUNCH_ALT: cfg_q.launch_altitude_threshold <= pwdata[22:0];
        REG_MAIN_ALT:   cfg_q.main_chute_altitude       <= pwdata[22:0];
        REG_COAST_N:    cfg_q.coast_samples_needed      <= pwdata[7:0];
        REG_APOGEE_N:   cfg_q.apogee_samples_needed     <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_ACCEL_THR:  prdata = {17'd0, cfg_q.accel_threshold};
      REG_LAUNCH_ALT: prdata = {9'd0, cfg_q.launch_altitude_threshold};
      REG_MAIN_ALT:   prdata = {9'd0, cfg_q.main_chute_altitude};
      REG_COAST_N:    prdata = {24'd0, cfg_q.coast_samples_needed};
      REG_APOGEE_N:   prdata = {24'd0, cfg_q.apogee_samples_needed};
      default:        prdata = '0;
    endcase
  end

  // input register moves into the result register when that slot frees up
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      accel_q <= $signed(s_axis_tdata[15:0]);
      alt_q   <= $signed(s_axis_tdata[39:16]);
    end
  end

  rfpd_phase_logic u_phase (
    .cfg_i      (cfg_q),
    .state_i    (state_q),
    .accel_z_i  (accel_q),
    .altitude_i (alt_q),
    .state_o    (state_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.phase         <= PH_IDLE;
      state_q.last_altitude <= '0;
      state_q.coast_run     <= '0;
      state_q.apogee_run    <= '0;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      phase_out_q <= state_d.phase;
      changed_q   <= state_d.phase != state_q.phase;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'd0, changed_q, phase_out_q};

endmodule

// ===== design/rfpd_check.sv =====
module rfpd_check (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [7:0]  m_axis_tdata
);
  import rfpd_pkg::*;

  logic              m_fire;
  logic              seen_q;
  logic [PhaseW-1:0] prev_phase_q;

  assign m_fire = m_axis_tvalid && m_axis_tready;

  // phase of the previous result transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q       <= 1'b0;
      prev_phase_q <= PH_IDLE;
    end else if (m_fire) begin
      seen_q       <= 1'b1;
      prev_phase_q <= m_axis_tdata[2:0];
    end
  end

  // a held result keeps its value
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // phases only move forward
  a_phase_forward: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_fire |-> m_axis_tdata[2:0] >= prev_phase_q)
    else $error("flight phase went backwards");

  // the change flag agrees with the phase sequence
  a_changed_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_fire && seen_q |-> m_axis_tdata[3] == (m_axis_tdata[2:0] != prev_phase_q))
    else $error("phase_changed disagrees with phase sequence");

  // an empty result slot never blocks the input
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output");

  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[7:4] == 4'd0)
    else $error("result padding bits set");

endmodule

bind rocket_flight_phase_detector rfpd_check u_rfpd_check (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

// ===== verif/tb_rocket_flight_phase_detector.sv =====
`timescale 1ns / 100ps

module tb_rocket_flight_phase_detector;
  import rfpd_pkg::*;

  localparam int AccMin = -32768;
  localparam int AccMax = 32767;
  localparam int AltMin = -8388608;
  localparam int AltMax = 8388607;

  // indexes past the register file, writes there must be dropped
  localparam logic [2:0] RegSpareLo = 3'd5;
  localparam logic [2:0] RegSpareHi = 3'd7;

  typedef struct packed {
    logic signed [AltW-1:0]   altitude;
    logic signed [AccelW-1:0] accel_z;
  } sample_t;

  typedef struct packed {
    logic              changed;
    logic [PhaseW-1:0] phase;
  } phase_report_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;   // [15:0] accel_z, [39:16] altitude
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;        // [2:0] flight_phase, [3] phase_changed
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  rocket_flight_phase_detector dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  cfg_t            regs_now;
  trk_state_t      plan_st;     // tracks the queued samples
  trk_state_t      flight_st;   // tracks the accepted samples
  trk_state_t      flight_next;
  phase_report_t   report_now;
  phase_report_t   report_want;
  sample_t         sample_q[$];
  phase_report_t   report_q[$];
  int              n_queued = 0;
  int              n_checked = 0;
  int              err_count = 0;
  int              seg_no = 0;
  int              send_idle_pct = 0;
  int              recv_stall_pct = 0;
  logic            hold_go = 1'b0;
  int              hold_left = 0;

  function automatic void note_error(string msg);
    err_count++;
    if (err_count <= 10) $display("ERROR @%0t: %s", $realtime, msg);
  endfunction

  function automatic trk_state_t step_flight(trk_state_t st, cfg_t c, sample_t s);
    int acc, alt, prev, athr, lthr, mthr;
    logic [PhaseW-1:0] nxt;
    acc  = $signed(s.accel_z);
    alt  = $signed(s.altitude);
    prev = $signed(st.last_altitude);
    athr = c.accel_threshold;
    lthr = c.launch_altitude_threshold;
    mthr = c.main_chute_altitude;
    nxt  = st.phase;
    case (st.phase)
      PH_IDLE: if (acc > athr || alt > lthr) nxt = PH_BOOST;
      PH_BOOST: if (acc < athr || alt > prev) nxt = PH_BURNOUT;
      PH_BURNOUT: begin
        if (acc < athr) begin
          if (st.coast_run != 8'hFF) st.coast_run = st.coast_run + 8'd1;
          if (st.coast_run >= c.coast_samples_needed) begin
            nxt = PH_COAST;
            st.coast_run = '0;
          end
        end else begin
          st.coast_run = '0;
        end
      end
      PH_COAST: begin
        if (alt < prev) begin
          if (st.apogee_run != 8'hFF) st.apogee_run = st.apogee_run + 8'd1;
          if (st.apogee_run >= c.apogee_samples_needed) begin
            nxt = PH_APOGEE;
            st.apogee_run = '0;
          end
        end else begin
          st.apogee_run = '0;
        end
      end
      PH_APOGEE: nxt = PH_DROGUE;
      PH_DROGUE: if (alt < mthr) nxt = PH_MAIN;
      PH_MAIN: if (acc < athr || alt < lthr) nxt = PH_LANDED;
      default: ;
    endcase
    st.last_altitude = s.altitude;
    st.phase = nxt;
    return st;
  endfunction

  // uniform, but one draw in four sits near each end so edges get hit often
  function automatic int rand_between(int lo, int hi);
    if (hi <= lo) return lo;
    case ($urandom_range(3))
      0: if (hi - lo > 7) lo = hi - 7;
      1: if (hi - lo > 7) hi = lo + 7;
      default: ;
    endcase
    return lo + int'($urandom_range(hi - lo));
  endfunction

  // move = 1: a sample that fires (or counts toward) the phase's exit
  // move = 0: a sample that keeps the phase where that is possible
  function automatic sample_t pick_sample(trk_state_t st, cfg_t c, bit move);
    int acc, alt, prev, athr, lthr, mthr;
    sample_t s;
    prev = $signed(st.last_altitude);
    athr = c.accel_threshold;
    lthr = c.launch_altitude_threshold;
    mthr = c.main_chute_altitude;
    acc  = rand_between(AccMin, AccMax);
    alt  = rand_between(AltMin, AltMax);
    case (st.phase)
      PH_IDLE: begin
        if (!move) begin
          acc = rand_between(AccMin, athr);
          alt = rand_between(AltMin, lthr);
        end else if (athr < AccMax && (lthr == AltMax || $urandom_range(1))) begin
          acc = rand_between(athr + 1, AccMax);
        end else if (lthr < AltMax) begin
          alt = rand_between(lthr + 1, AltMax);
        end
      end
      PH_BOOST: begin
        if (!move) begin
          acc = rand_between(athr, AccMax);
          alt = rand_between(AltMin, prev);
        end else if (prev == AltMax || $urandom_range(1)) begin
          acc = rand_between(AccMin, athr - 1);
        end else begin
          alt = rand_between(prev + 1, AltMax);
        end
      end
      PH_BURNOUT: acc = move ? rand_between(AccMin, athr - 1) : rand_between(athr, AccMax);
      PH_COAST: begin
        // small altitude steps keep the descent away from the range ends
        if (move && prev > AltMin)
          alt = rand_between((prev - 4000 < AltMin) ? AltMin : prev - 4000, prev - 1);
        else
          alt = rand_between(prev, (prev + 4000 > AltMax) ? AltMax : prev + 4000);
      end
      PH_DROGUE: alt = move ? rand_between(AltMin, mthr - 1) : rand_between(mthr, AltMax);
      PH_MAIN: begin
        if (!move) begin
          acc = rand_between(athr, AccMax);
          alt = rand_between(lthr, AltMax);
        end else if ($urandom_range(1)) begin
          acc = rand_between(AccMin, athr - 1);
        end else begin
          alt = rand_between(AltMin, lthr - 1);
        end
      end
      default: ;
    endcase
    s.accel_z  = acc[15:0];
    s.altitude = alt[23:0];
    return s;
  endfunction

  function automatic logic [31:0] reg_value(logic [2:0] idx);
    case (idx)
      REG_ACCEL_THR:  return 32'(regs_now.accel_threshold);
      REG_LAUNCH_ALT: return 32'(regs_now.launch_altitude_threshold);
      REG_MAIN_ALT:   return 32'(regs_now.main_chute_altitude);
      REG_COAST_N:    return 32'(regs_now.coast_samples_needed);
      REG_APOGEE_N:   return 32'(regs_now.apogee_samples_needed);
      default:        return '0;
    endcase
  endfunction

  task automatic apb_access(input logic wr, input logic [2:0] idx, input logic [31:0] wdata,
                            output logic [31:0] rdata);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    while (!pready) begin
      @(posedge clk_i);
      @(negedge clk_i);
    end
    rdata = prdata;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_reg(logic [2:0] idx, logic [31:0] val);
    logic [31:0] unused;
    apb_access(1'b1, idx, val, unused);
    case (idx)
      REG_ACCEL_THR:  regs_now.accel_threshold = val[14:0];
      REG_LAUNCH_ALT: regs_now.launch_altitude_threshold = val[22:0];
      REG_MAIN_ALT:   regs_now.main_chute_altitude = val[22:0];
      REG_COAST_N:    regs_now.coast_samples_needed = val[7:0];
      REG_APOGEE_N:   regs_now.apogee_samples_needed = val[7:0];
      default: ;
    endcase
  endtask

  task automatic check_all_regs();
    logic [31:0] rd;
    for (int i = 0; i <= REG_APOGEE_N; i++) begin
      apb_access(1'b0, 3'(i), '0, rd);
      if (rd !== reg_value(3'(i)))
        note_error($sformatf("reg %0d read %0h, want %0h", i, rd, reg_value(3'(i))));
    end
  endtask

  task automatic push_sample(sample_t s);
    sample_q.push_back(s);
    plan_st = step_flight(plan_st, regs_now, s);
    n_queued++;
  endtask

  task automatic push_pair(int acc, int alt);
    sample_t s;
    s.accel_z  = acc[15:0];
    s.altitude = alt[23:0];
    push_sample(s);
  endtask

  task automatic next_idling();
    case (seg_no % 4)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 62; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 62; end
      default: begin send_idle_pct = 30; recv_stall_pct = 30; end
    endcase
    seg_no++;
  endtask

  // n samples that keep the current phase; counter phases see runs that break
  task automatic fly_steady(int n);
    sample_t s;
    trk_state_t probe;
    next_idling();
    repeat (n) begin
      if ($urandom_range(99) < 8) begin
        s.accel_z  = 16'($urandom);
        s.altitude = 24'($urandom);
      end else begin
        s = pick_sample(plan_st, regs_now, $urandom_range(99) < 80);
      end
      probe = step_flight(plan_st, regs_now, s);
      if (probe.phase != plan_st.phase) s = pick_sample(plan_st, regs_now, 1'b0);
      push_sample(s);
    end
  endtask

  task automatic fly_to_next();
    logic [PhaseW-1:0] from;
    int guard;
    from  = plan_st.phase;
    guard = 0;
    while (plan_st.phase == from && guard < 2000) begin
      push_sample(pick_sample(plan_st, regs_now, $urandom_range(99) >= 15));
      guard++;
    end
  endtask

  task automatic drain();
    while (n_checked < n_queued) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  // sample driver, expectation computed on each accepted transaction
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        flight_next        = step_flight(flight_st, regs_now, sample_t'(s_axis_tdata));
        report_now.phase   = flight_next.phase;
        report_now.changed = flight_next.phase != flight_st.phase;
        report_q.push_back(report_now);
        flight_st = flight_next;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (sample_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          s_axis_tdata  <= sample_q.pop_front();
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (hold_go) hold_left <= 300;
    else if (hold_left != 0) hold_left <= hold_left - 1;
  end

  // result monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        n_checked++;
        if (report_q.size() == 0) begin
          note_error($sformatf("unexpected result: phase %0d changed %0b",
                               m_axis_tdata[2:0], m_axis_tdata[3]));
        end else begin
          report_want = report_q.pop_front();
          if (m_axis_tdata[2:0] !== report_want.phase)
            note_error($sformatf("flight_phase %0d, want %0d",
                                 m_axis_tdata[2:0], report_want.phase));
          if (m_axis_tdata[3] !== report_want.changed)
            note_error($sformatf("phase_changed %0b, want %0b",
                                 m_axis_tdata[3], report_want.changed));
        end
      end
      m_axis_tready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  initial begin
    regs_now = {ACCEL_THR_RST, LAUNCH_ALT_RST, MAIN_ALT_RST, COAST_N_RST, APOGEE_N_RST};
    plan_st = '0;
    plan_st.phase = PH_IDLE;
    flight_st = plan_st;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    check_all_regs();

    // defaults: samples sitting exactly on a threshold do not launch
    push_pair(ACCEL_THR_RST, LAUNCH_ALT_RST);
    push_pair(AccMin, AltMin);
    push_pair(0, 0);
    drain();

    // all-ones writes clip to the field maxima; nothing can launch then
    set_reg(REG_ACCEL_THR, '1);
    set_reg(REG_LAUNCH_ALT, '1);
    set_reg(REG_MAIN_ALT, '1);
    set_reg(REG_COAST_N, '1);
    set_reg(REG_APOGEE_N, '1);
    set_reg(RegSpareLo, $urandom);
    set_reg(RegSpareHi, $urandom);
    check_all_regs();
    push_pair(AccMax, AltMax);
    push_pair(AccMax, AltMin);
    push_pair(AccMin, AltMax);
    push_pair(-1, -1);
    push_pair(1, 1);
    drain();

    set_reg(REG_ACCEL_THR, '0);
    set_reg(REG_LAUNCH_ALT, '0);
    check_all_regs();
    push_pair(0, 0);
    push_pair(AccMin, 0);
    push_pair(0, AltMin);
    push_pair(-1, -1);
    drain();

    // idle, then launch
    set_reg(REG_ACCEL_THR, $urandom);
    set_reg(REG_LAUNCH_ALT, $urandom);
    fly_steady(140);
    fly_to_next();
    drain();

    // boost
    set_reg(REG_ACCEL_THR, $urandom);
    fly_steady(120);
    fly_to_next();
    drain();

    // burnout: long runs that never reach the count, then a short count
    set_reg(REG_COAST_N, 32'hFF);
    fly_steady(140);
    drain();
    fly_steady(140);
    drain();
    set_reg(REG_COAST_N, $urandom_range(8, 1));
    fly_to_next();
    drain();

    // coast: zero run length fires on the first falling sample
    set_reg(REG_APOGEE_N, 32'hFF);
    fly_steady(140);
    drain();
    fly_steady(140);
    drain();
    set_reg(REG_APOGEE_N, '0);
    fly_to_next();
    fly_to_next();
    drain();

    // drogue, with a long receiver hold-off to back up the input
    set_reg(REG_MAIN_ALT, $urandom);
    set_reg(REG_APOGEE_N, $urandom);
    check_all_regs();
    fly_steady(140);
    @(posedge clk_i);
    hold_go <= 1'b1;
    @(posedge clk_i);
    hold_go <= 1'b0;
    fly_to_next();
    drain();

    // main descent
    set_reg(REG_ACCEL_THR, $urandom);
    set_reg(REG_LAUNCH_ALT, $urandom);
    fly_steady(140);
    fly_to_next();
    drain();

    // landed is terminal whatever the settings
    for (int k = 0; k < 4; k++) begin
      set_reg(REG_ACCEL_THR, $urandom);
      set_reg(REG_LAUNCH_ALT, $urandom);
      set_reg(REG_MAIN_ALT, (k == 0) ? '0 : $urandom);
      set_reg(REG_COAST_N, (k == 0) ? '0 : $urandom);
      set_reg(REG_APOGEE_N, $urandom);
      check_all_regs();
      fly_steady(50);
      drain();
    end

    repeat (10) @(posedge clk_i);
    if (report_q.size() != 0)
      note_error($sformatf("%0d results never arrived", report_q.size()));
    if (err_count == 0) begin
      $display("tb_rocket_flight_phase_detector: done, clean");
    end else begin
      $display("tb_rocket_flight_phase_detector: done, errors");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("TIMEOUT");
    $display("tb_rocket_flight_phase_detector: done, errors");
    $finish;
  end

endmodule

// ===== filelist.f =====
design/rfpd_pkg.sv
design/rfpd_phase_logic.sv
design/rocket_flight_phase_detector.sv
design/rfpd_check.sv
verif/tb_rocket_flight_phase_detector.sv
